// ===== hw/rtl/awpb_pkg.sv =====
// shared constants and control types for the age weighted pixel blend unit
// no dependencies; imported by every awpb module
`timescale 1ns / 1ps

package awpb_pkg;

   localparam int CHANNELS    = 4;
   localparam int CHAN_W      = 16;
   localparam int AGE_W       = 16;
   localparam int WEIGHT_W    = 16;
   localparam int DEN_W       = AGE_W + 1;
   localparam int DIV_STEPS   = WEIGHT_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   localparam int PIXELS      = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int PIXEL_SHIFT = $clog2(PIXELS + 1) - 1;

   localparam int PART_W      = CHAN_W + $clog2(CHANNELS);
   localparam int SUM_W       = 28;
   localparam int MEAN_W      = 18;

   localparam logic [CHAN_W-1:0] CHAN_MASK =
      CHAN_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
   localparam logic [MEAN_W-1:0] MEAN_MAX  = 18'd262140;

   typedef logic [CHANNELS-1:0][CHAN_W-1:0] chan_vec_type;

   typedef struct packed {
      logic mul_en;
      logic add_en;
   } lane_ctl_type;

   typedef struct packed {
      logic commit;
      logic last;
   } merge_ctl_type;

endpackage

// ===== hw/rtl/awpb_div.sv =====
// bit serial divider forming the blend weight age/(age+4) in unsigned q0.16
// depends on awpb_pkg
`timescale 1ns / 1ps

module awpb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [awpb_pkg::AGE_W-1:0]    age,
   output logic                          done,
   output logic [awpb_pkg::WEIGHT_W-1:0] weight
);
   import awpb_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [WEIGHT_W-1:0]  sh_ff, sh_in;
   logic [DEN_W-1:0]     start_den;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;
   logic                 busy;

   assign busy      = (cnt_ff != '0);
   assign start_den = {1'b0, age} + DEN_W'(4);
   assign trial     = {rem_ff, sh_ff[WEIGHT_W-1]};
   assign diff      = trial - {1'b0, den_ff};
   assign fits      = (trial >= {1'b0, den_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      den_in  = den_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         den_in = start_den;
         rem_in = {1'b0, age};
         // low dividend bits hold the rounding term (age+4)/2
         sh_in  = start_den[DEN_W-1:1];
      end else if (busy) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         sh_in   = {sh_ff[WEIGHT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign weight = sh_ff;

endmodule

// ===== hw/rtl/awpb_lane.sv =====
// one channel lane: weighted blend of history and sample plus absolute change
// depends on awpb_pkg
`timescale 1ns / 1ps

module awpb_lane (
   input  logic                          clock,
   input  awpb_pkg::lane_ctl_type        ctl,
   input  logic [awpb_pkg::CHAN_W-1:0]   hist,
   input  logic [awpb_pkg::CHAN_W-1:0]   samp,
   input  logic [awpb_pkg::WEIGHT_W-1:0] weight,
   output logic [awpb_pkg::CHAN_W-1:0]   blended,
   output logic [awpb_pkg::CHAN_W-1:0]   delta
);
   import awpb_pkg::*;

   localparam int PROD_W = 2 * (CHAN_W + 1);
   localparam int ACC_W  = PROD_W + 1;

   logic signed [CHAN_W:0]   diff;
   logic signed [CHAN_W:0]   wt_s;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc;
   logic [CHAN_W-1:0]        nv_ff, nv_in;
   logic [CHAN_W-1:0]        delta_ff, delta_in;

   // a*h + (1-a)*s  ==  s + a*(h-s)
   assign diff    = $signed({1'b0, hist}) - $signed({1'b0, samp});
   assign wt_s    = $signed({1'b0, weight});
   assign prod_in = wt_s * diff;

   // sample term with the half lsb rounding constant folded in
   assign acc = $signed({(ACC_W - 2 * CHAN_W)'(0), samp, 16'h8000})
              + ACC_W'(prod_ff);
   assign nv_in    = acc[2*CHAN_W-1:CHAN_W];
   assign delta_in = (hist > nv_in) ? (hist - nv_in) : (nv_in - hist);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.add_en) begin
         nv_ff    <= nv_in;
         delta_ff <= delta_in;
      end
   end

   assign blended = nv_ff;
   assign delta   = delta_ff;

endmodule

// ===== hw/rtl/awpb_merge.sv =====
// merges lane changes into the saturating block sum and forms the mean residual
// depends on awpb_pkg
`timescale 1ns / 1ps

module awpb_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  awpb_pkg::merge_ctl_type       ctl,
   input  awpb_pkg::chan_vec_type        delta,
   output logic [awpb_pkg::MEAN_W-1:0]   mean
);
   import awpb_pkg::*;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PART_W-1:0] part;
   logic [SUM_W:0]    total;
   logic [SUM_W-1:0]  sat;
   logic [SUM_W-1:0]  scaled;

   always_comb begin
      part = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         part = part + PART_W'(delta[i]);
      end
   end

   assign total  = {1'b0, sum_ff} + (SUM_W + 1)'(part);
   assign sat    = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
   assign scaled = sat >> PIXEL_SHIFT;
   assign mean   = (scaled > SUM_W'(MEAN_MAX)) ? MEAN_MAX : scaled[MEAN_W-1:0];

   always_comb begin
      sum_in = sum_ff;
      if (ctl.commit) begin
         sum_in = ctl.last ? '0 : sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== hw/rtl/age_weighted_pixel_blend_unit.sv =====
// a request in a block steps through the two stage lane multiply (mul, add) and
//   the merge state; one that opens a block first waits in the weight state
//   for the 16 step bit serial weight divider; req_stall holds off the next
//   request until the last leaves merge, where rsp_stall can hold it
// reset: synchronous, clears the sequencer, block sum, open block flag, rsp_valid
// top level; depends on awpb_pkg, awpb_div, awpb_lane, awpb_merge
`timescale 1ns / 1ps

module age_weighted_pixel_blend_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_history_red,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_history_green,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_history_blue,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_history_opacity,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_sample_red,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_sample_green,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_sample_blue,
   input  logic [awpb_pkg::CHAN_W-1:0]   req_sample_opacity,
   input  logic [awpb_pkg::AGE_W-1:0]    req_block_age,
   input  logic                          req_last_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [awpb_pkg::CHAN_W-1:0]   rsp_blended_red,
   output logic [awpb_pkg::CHAN_W-1:0]   rsp_blended_green,
   output logic [awpb_pkg::CHAN_W-1:0]   rsp_blended_blue,
   output logic [awpb_pkg::CHAN_W-1:0]   rsp_blended_opacity,
   output logic [awpb_pkg::MEAN_W-1:0]   rsp_mean_residual,
   output logic                          rsp_residual_valid
);
   import awpb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_MUL,
      ST_ADD,
      ST_MERGE
   } state_type;

   state_type           state_ff, state_in;
   logic                inside_ff, inside_in;
   logic                last_ff, last_in;
   chan_vec_type        hist_ff, hist_in;
   chan_vec_type        samp_ff, samp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   chan_vec_type        rsp_blend_ff, rsp_blend_in;
   logic [MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic                rsp_resv_ff, rsp_resv_in;

   chan_vec_type        req_hist;
   chan_vec_type        req_samp;
   chan_vec_type        lane_blend;
   chan_vec_type        lane_delta;
   logic                accept;
   logic                commit;
   logic                div_start;
   logic                div_done;
   logic [WEIGHT_W-1:0] weight;
   logic [MEAN_W-1:0]   merge_mean;
   lane_ctl_type        lane_ctl;
   merge_ctl_type       merge_ctl;

   assign req_hist = {req_history_opacity, req_history_blue,
                      req_history_green, req_history_red};
   assign req_samp = {req_sample_opacity, req_sample_blue,
                      req_sample_green, req_sample_red};

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == ST_MERGE) && (!rsp_valid_ff || !rsp_stall);
   assign div_start = accept && !inside_ff;

   assign lane_ctl.mul_en = (state_ff == ST_MUL);
   assign lane_ctl.add_en = (state_ff == ST_ADD);
   assign merge_ctl.commit = commit;
   assign merge_ctl.last   = last_ff;

   awpb_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .age    (req_block_age),
      .done   (div_done),
      .weight (weight)
   );

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      awpb_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .hist    (hist_ff[g]),
         .samp    (samp_ff[g]),
         .weight  (weight),
         .blended (lane_blend[g]),
         .delta   (lane_delta[g])
      );
   end

   awpb_merge u_merge (
      .clock (clock),
      .reset (reset),
      .ctl   (merge_ctl),
      .delta (lane_delta),
      .mean  (merge_mean)
   );

   always_comb begin
      state_in     = state_ff;
      inside_in    = inside_ff;
      last_in      = last_ff;
      hist_in      = hist_ff;
      samp_in      = samp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_blend_in = rsp_blend_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_resv_in  = rsp_resv_ff;

      if (accept) begin
         last_in = req_last_pixel;
         for (int i = 0; i < CHANNELS; i++) begin
            hist_in[i] = req_hist[i] & CHAN_MASK;
            samp_in[i] = req_samp[i] & CHAN_MASK;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = inside_ff ? ST_MUL : ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (commit) begin
               state_in     = ST_IDLE;
               inside_in    = !last_ff;
               rsp_valid_in = 1'b1;
               rsp_blend_in = lane_blend;
               rsp_mean_in  = last_ff ? merge_mean : '0;
               rsp_resv_in  = last_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      hist_ff      <= hist_in;
      samp_ff      <= samp_in;
      rsp_blend_ff <= rsp_blend_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_resv_ff  <= rsp_resv_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_blended_red     = rsp_blend_ff[0];
   assign rsp_blended_green   = rsp_blend_ff[1];
   assign rsp_blended_blue    = rsp_blend_ff[2];
   assign rsp_blended_opacity = rsp_blend_ff[3];
   assign rsp_mean_residual   = rsp_mean_ff;
   assign rsp_residual_valid  = rsp_resv_ff;

   a_div_done_in_weight : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WEIGHT))
      else $error("weight divider finished outside the weight state");

   a_mean_zero_unless_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_residual_valid) |-> (rsp_mean_residual == '0))
      else $error("mean residual nonzero on a pixel that does not close a block");

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

endmodule
